// ===== rtl/bsrp_pkg.sv =====
package bsrp_pkg;

  localparam int unsigned STORE_BYTES_DEFAULT = 4096;

  localparam logic [2:0] BIT_LAST = 3'd7;

  typedef enum logic [1:0] {
    FUNC_SET   = 2'd0,
    FUNC_GET   = 2'd1,
    FUNC_COUNT = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_COUNT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic bit_upd;
    logic cnt_load;
    logic cnt_run;
    logic clr_run;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_bitop;
    logic is_set;
    logic is_count;
    logic oor;
    logic get_hit;
    logic cnt_empty;
    logic cnt_busy;
    logic out_free;
  } dp_sts_t;

  function automatic logic [3:0] ones8(logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b000, b[k]};
    end
    return n;
  endfunction

endpackage

// ===== rtl/bsrp_ram.sv =====
module bsrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bsrp_ctrl.sv =====
module bsrp_ctrl
  import bsrp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_run = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.is_bitop) begin
          if (!sts_i.oor && (sts_i.is_set || sts_i.get_hit)) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end else if (sts_i.is_count) begin
          cmd_o.cnt_load = 1'b1;
          state_d = sts_i.cnt_empty ? ST_DONE : ST_COUNT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.bit_upd = 1'b1;
        state_d       = ST_DONE;
      end
      ST_COUNT: begin
        cmd_o.cnt_run = 1'b1;
        if (!sts_i.cnt_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/bsrp_dp.sv =====
module bsrp_dp
  import bsrp_pkg::*;
#(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [1:0]  func_i,
  input  logic [14:0] bit_offset_i,
  input  logic        bit_value_i,
  input  logic signed [12:0] range_start_i,
  input  logic signed [12:0] range_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        bit_out_o,
  output logic [15:0] ones_count_o,
  output logic        out_of_range_o
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned LW = $clog2(STORE_BYTES + 1);
  localparam int unsigned IW = (LW > 12) ? LW : 12;
  localparam int unsigned SW = ((LW > 13) ? LW : 13) + 2;

  func_e              func_q;
  logic [14:0]        offset_q;
  logic               value_q;
  logic signed [12:0] start_q, end_q;

  logic [LW-1:0]      len_q, len_d;
  logic [AW-1:0]      clr_q;
  logic [LW-1:0]      ptr_q, last_q;
  logic               rd_valid_q;
  logic [15:0]        acc_q;
  logic               res_bit_q;

  logic               out_valid_q, out_bit_q, out_oor_q;
  logic [15:0]        out_ones_q;

  logic [IW-1:0]      idx_w;
  logic [2:0]         shift;
  logic               oor;
  logic               issue;
  logic [AW-1:0]      addr;
  logic               we;
  logic [7:0]         wdata, rdata, new_byte;

  logic signed [SW-1:0] len_s, st_a, en_a;
  logic                 empty;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_e'(func_i);
      offset_q <= bit_offset_i;
      value_q  <= bit_value_i;
      start_q  <= range_start_i;
      end_q    <= range_end_i;
    end
  end

  assign idx_w = IW'(offset_q[14:3]);
  assign shift = BIT_LAST - offset_q[2:0];
  assign oor   = idx_w >= IW'(STORE_BYTES);

  // resolve count range against current length
  assign len_s = $signed({{(SW-LW){1'b0}}, len_q});
  always_comb begin
    st_a = SW'(start_q);
    en_a = SW'(end_q);
    if (st_a[SW-1]) st_a = st_a + len_s;
    if (en_a[SW-1]) en_a = en_a + len_s;
    if (st_a[SW-1]) st_a = '0;
    if (en_a[SW-1]) en_a = '0;
    if (en_a >= len_s) en_a = len_s - SW'(1);
    empty = (len_q == '0) || (st_a > en_a);
  end

  assign issue = ptr_q <= last_q;

  always_comb begin
    if (cmd_i.clr_run) begin
      addr = clr_q;
    end else if (cmd_i.cnt_run) begin
      addr = ptr_q[AW-1:0];
    end else begin
      addr = idx_w[AW-1:0];
    end
  end

  always_comb begin
    new_byte        = rdata;
    new_byte[shift] = value_q;
  end

  assign we    = cmd_i.clr_run || (cmd_i.bit_upd && (func_q == FUNC_SET));
  assign wdata = cmd_i.clr_run ? 8'h00 : new_byte;

  bsrp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    len_d = len_q;
    if (cmd_i.bit_upd && (func_q == FUNC_SET) && (IW'(len_q) < idx_w + IW'(1))) begin
      len_d = LW'(idx_w + IW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      clr_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      if (cmd_i.clr_run) begin
        clr_q <= clr_q + AW'(1);
      end
      rd_valid_q <= cmd_i.cnt_run && issue;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q     <= '0;
      res_bit_q <= 1'b0;
    end
    if (cmd_i.bit_upd) begin
      res_bit_q <= rdata[shift];
    end
    if (cmd_i.cnt_load) begin
      ptr_q  <= st_a[LW-1:0];
      last_q <= en_a[LW-1:0];
    end else if (cmd_i.cnt_run && issue) begin
      ptr_q <= ptr_q + LW'(1);
    end
    if (cmd_i.cnt_run && rd_valid_q) begin
      acc_q <= acc_q + 16'(ones8(rdata));
    end
    if (cmd_i.out_load) begin
      out_bit_q  <= res_bit_q;
      out_ones_q <= acc_q;
      out_oor_q  <= sts_o.is_bitop && oor;
    end
  end

  assign sts_o.clr_last  = clr_q == AW'(STORE_BYTES - 1);
  assign sts_o.is_bitop  = (func_q == FUNC_SET) || (func_q == FUNC_GET);
  assign sts_o.is_set    = func_q == FUNC_SET;
  assign sts_o.is_count  = func_q == FUNC_COUNT;
  assign sts_o.oor       = oor;
  assign sts_o.get_hit   = idx_w < IW'(len_q);
  assign sts_o.cnt_empty = empty;
  assign sts_o.cnt_busy  = issue || rd_valid_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign bit_out_o      = out_bit_q;
  assign ones_count_o   = out_ones_q;
  assign out_of_range_o = out_oor_q;

endmodule

// ===== rtl/bitmap_store_with_range_popcount_top.sv =====
// channel  dir  tdata (low bit up)                               tuser
// s_axis   in   bit_offset 15, bit_value 1, range_start 13,        func 2
//               range_end 13, zero fill to 48
// m_axis   out  bit_out 1, ones_count 16, zero fill to 24          out_of_range 1
//
// set and get go through decode, one ram read and, for set, a write back before the result
// count does one ram read per byte in range into the adder
// out of range, get beyond length, empty count and unused func go from decode straight to done
// after reset a clearing pass writes zero to every ram byte, s_axis_tready low
// one request in flight; a new request is taken while a result waits in the output register
// a stalled m_axis holds the result and keeps the next one in the done state
module bitmap_store_with_range_popcount_top
  import bsrp_pkg::*;
#(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // bit_offset, bit_value, range_start, range_end
  input  logic [1:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // bit_out, ones_count
  output logic        m_axis_tuser   // out_of_range
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        bit_out;
  logic [15:0] ones_count;

  bsrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsrp_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (s_axis_tuser),
    .bit_offset_i   (s_axis_tdata[14:0]),
    .bit_value_i    (s_axis_tdata[15]),
    .range_start_i  ($signed(s_axis_tdata[28:16])),
    .range_end_i    ($signed(s_axis_tdata[41:29])),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .bit_out_o      (bit_out),
    .ones_count_o   (ones_count),
    .out_of_range_o (m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0, ones_count, bit_out};

endmodule

// ===== tb/sv/bitmap_store_with_range_popcount_top_tb.sv =====
`timescale 1ns / 1ps

module bitmap_store_with_range_popcount_top_tb;
  import bsrp_pkg::*;

  localparam int unsigned STORE_N    = STORE_BYTES_DEFAULT;
  localparam int unsigned NUM_DIR    = 25;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_REQS = 232;
  localparam int unsigned DRAIN_CYC  = 40;
  localparam int unsigned CYC_LIMIT  = 2000000;
  localparam int unsigned MAX_SHOWN  = 10;

  localparam logic [12:0] IDX_MIN = 13'h1000;
  localparam logic [12:0] IDX_MAX = 13'h0FFF;

  typedef struct packed {
    func_e       func;
    logic [14:0] off;
    logic        val;
    logic [12:0] rs;
    logic [12:0] re;
  } req_t;

  typedef struct packed {
    logic        bit_out;
    logic [15:0] ones;
    logic        oor;
  } resp_t;

  typedef struct packed {
    req_t  req;
    logic  typed;
    resp_t resp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cyc_cnt = 0;

  logic [7:0]  store_img [STORE_N];
  int unsigned store_len;
  resp_t       result_q [$];
  dir_row_t    dir_tab [NUM_DIR];

  bitmap_store_with_range_popcount_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic resp_t calc_bit_result(input req_t r);
    resp_t       res;
    int unsigned idx;
    int unsigned sh;
    int          s;
    int          e;
    int          len;
    res = '0;
    idx = 32'(r.off >> 3);
    sh  = 7 - r.off[2:0];
    len = store_len;
    case (r.func)
      FUNC_SET, FUNC_GET: begin
        if (idx >= STORE_N) begin
          res.oor = 1'b1;
        end else if (r.func == FUNC_SET) begin
          res.bit_out = store_img[idx][sh];
          store_img[idx][sh] = r.val;
          if (store_len < idx + 1) store_len = idx + 1;
        end else if (idx < store_len) begin
          res.bit_out = store_img[idx][sh];
        end
      end
      FUNC_COUNT: begin
        s = int'($signed(r.rs));
        e = int'($signed(r.re));
        if (s < 0) s += len;
        if (e < 0) e += len;
        if (s < 0) s = 0;
        if (e < 0) e = 0;
        if (e >= len) e = len - 1;
        if (len != 0 && s <= e) begin
          for (int i = s; i <= e; i++) begin
            res.ones = res.ones + 16'($countones(store_img[i]));
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   k;
    int   s;
    int   e;
    r.func = FUNC_NONE;
    r.off  = 15'($urandom);
    r.val  = 1'($urandom);
    r.rs   = 13'($urandom);
    r.re   = 13'($urandom);
    k = $urandom_range(99);
    if (k < 38) r.func = FUNC_SET;
    else if (k < 62) r.func = FUNC_GET;
    else if (k < 95) r.func = FUNC_COUNT;
    k = $urandom_range(99);
    if (k < 50) r.off = 15'($urandom_range(255));
    else if (k < 80) r.off = 15'h7F00 | 15'($urandom_range(255));
    if (r.func == FUNC_COUNT) begin
      k = $urandom_range(99);
      // short windows at the front, at the back and in the middle, rare long spans
      if (k < 45) begin
        s = int'($urandom_range(40));
        e = s + int'($urandom_range(14)) - 2;
        if (e < 0) e = 0;
        r.rs = s[12:0];
        r.re = e[12:0];
      end else if (k < 80) begin
        s = -int'($urandom_range(40, 1));
        e = s + int'($urandom_range(14)) - 2;
        if (e >= 0) e = -1;
        r.rs = s[12:0];
        r.re = e[12:0];
      end else if (k < 92) begin
        s = int'($urandom_range(4095));
        e = s + int'($urandom_range(12)) - 2;
        if (e > 4095) e = 4095;
        if (e < 0) e = 0;
        r.rs = s[12:0];
        r.re = e[12:0];
      end
    end
    return r;
  endfunction

  task automatic send_req(input req_t r, input logic typed, input resp_t typed_resp);
    resp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, r.re, r.rs, r.val, r.off};
    s_axis_tuser  <= r.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = calc_bit_result(r);
    result_q.push_back(typed ? typed_resp : p);
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    resp_t got;
    resp_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.bit_out = m_axis_tdata[0];
      got.ones    = m_axis_tdata[16:1];
      got.oor     = m_axis_tuser;
      if (result_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
          $display("unexpected result: bit_out %0d ones %0d oor %0d",
                   got.bit_out, got.ones, got.oor);
      end else begin
        want = result_q.pop_front();
        if (got.bit_out !== want.bit_out || got.ones !== want.ones || got.oor !== want.oor) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("mismatch: expected bit_out %0d ones %0d oor %0d, got %0d %0d %0d",
                     want.bit_out, want.ones, want.oor, got.bit_out, got.ones, got.oor);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYC_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORE_N; i++) store_img[i] = '0;
    store_len = 0;
    dir_tab = '{
      // fresh store
      '{'{FUNC_GET,   15'd0,     1'b0, 13'd0,   13'd0},   1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_GET,   15'h7FFF,  1'b1, 13'd0,   13'd0},   1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_COUNT, 15'd0,     1'b0, 13'd0,   13'h1FFF}, 1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_COUNT, 15'd0,     1'b0, IDX_MIN, IDX_MAX}, 1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_NONE,  15'h7FFF,  1'b1, 13'h1FFF, 13'h1FFF}, 1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_SET,   15'd0,     1'b1, 13'd0,   13'd0},   1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_SET,   15'd0,     1'b1, 13'd0,   13'd0},   1'b1, '{1'b1, 16'd0, 1'b0}},
      '{'{FUNC_GET,   15'd0,     1'b0, 13'd0,   13'd0},   1'b1, '{1'b1, 16'd0, 1'b0}},
      '{'{FUNC_GET,   15'd1,     1'b0, 13'd0,   13'd0},   1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_SET,   15'd7,     1'b1, 13'd0,   13'd0},   1'b0, '0},
      '{'{FUNC_SET,   15'd23,    1'b1, 13'd0,   13'd0},   1'b0, '0},
      // beyond length
      '{'{FUNC_GET,   15'd24,    1'b0, 13'd0,   13'd0},   1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_COUNT, 15'd0,     1'b0, 13'd0,   13'd0},   1'b0, '0},
      '{'{FUNC_COUNT, 15'd0,     1'b0, 13'd0,   13'h1FFF}, 1'b0, '0},
      '{'{FUNC_COUNT, 15'd0,     1'b0, 13'h1FFF, 13'h1FFF}, 1'b0, '0},
      '{'{FUNC_COUNT, 15'd0,     1'b0, 13'd2,   13'd1},   1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_COUNT, 15'd0,     1'b0, -13'sd100, 13'd100}, 1'b0, '0},
      '{'{FUNC_COUNT, 15'd0,     1'b0, IDX_MAX, IDX_MAX}, 1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_SET,   15'd0,     1'b0, 13'd0,   13'd0},   1'b1, '{1'b1, 16'd0, 1'b0}},
      // last bit of the store
      '{'{FUNC_SET,   15'h7FFF,  1'b1, 13'd0,   13'd0},   1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{FUNC_GET,   15'h7FFF,  1'b0, 13'd0,   13'd0},   1'b1, '{1'b1, 16'd0, 1'b0}},
      '{'{FUNC_SET,   15'h7FF8,  1'b1, 13'd0,   13'd0},   1'b0, '0},
      '{'{FUNC_COUNT, 15'd0,     1'b0, 13'h1FFF, 13'h1FFF}, 1'b0, '0},
      '{'{FUNC_COUNT, 15'd0,     1'b0, IDX_MIN, IDX_MAX}, 1'b0, '0},
      '{'{FUNC_COUNT, 15'd0,     1'b0, IDX_MAX, IDX_MIN}, 1'b1, '{1'b0, 16'd0, 1'b0}}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].resp);
    wait_results_done();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 56; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 56; end
        default: begin send_idle_pct <= 18; recv_stall_pct <= 18; end
      endcase
      for (int n = 0; n < PHASE_REQS; n++) send_req(rand_req(), 1'b0, '0);
      wait_results_done();
    end

    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bsrp_pkg.sv
rtl/bsrp_ram.sv
rtl/bsrp_ctrl.sv
rtl/bsrp_dp.sv
rtl/bitmap_store_with_range_popcount_top.sv
tb/sv/bitmap_store_with_range_popcount_top_tb.sv
